// File: rtl/mcpwm_pkg.sv
// shared types, constants and arithmetic helpers for the midi cc to pwm block
package mcpwm_pkg;

  localparam int unsigned SEGMENTS = 4;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INTERVAL = 2'd0,
    CFG_SEG_MAX  = 2'd1,
    CFG_FORCED   = 2'd2
  } cfg_idx_e;

  localparam logic [15:0] INTERVAL_RST = 16'd10;
  localparam logic [6:0]  SEG_MAX_RST  = 7'd55;
  localparam logic [2:0]  FORCED_RST   = 3'd4;

  localparam logic       KIND_TICK      = 1'b0;
  localparam logic       KIND_CC        = 1'b1;
  localparam logic [4:0] MIDI_CH_ACTIVE = 5'd1;

  localparam logic [6:0] CC_AUDIO     = 7'd0;
  localparam logic [6:0] CC_AUX_FIRST = 7'd2;
  localparam logic [6:0] CC_AUX_LAST  = 7'd4;
  localparam logic [6:0] CC_SEG_FIRST = 7'd30;

  localparam int unsigned AUX_COUNT = 3;
  localparam int unsigned AUX_IDX_W = 2;

  localparam logic [6:0] AUDIO_SLOPE = 7'd107;
  localparam logic [7:0] AUDIO_FLOOR = 8'd10;
  localparam logic [7:0] DBL_KNEE    = 8'd128;

  localparam logic [9:0]  SEG_BASE       = 10'd512;
  localparam int unsigned SEG_STEP_LOG2  = 7;
  localparam logic [9:0]  OUT_SPAN       = 10'd806;
  localparam logic [9:0]  OUT_FLOOR      = 10'd130;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_MAP,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic apply;
    logic mul;
    logic scale;
    logic map;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

  // floor(x / 127) for x < 16384, by reciprocal multiply
  function automatic logic [7:0] div127(input logic [13:0] x);
    logic [21:0] t;
    t = 22'(x) * 22'd129 + 22'd129;
    return t[21:14];
  endfunction

  // floor(n / 1023) for n < 1023 * 1024, by reciprocal multiply
  function automatic logic [9:0] div1023(input logic [19:0] n);
    logic [29:0] t;
    t = 30'(n) * 30'd1025 + 30'd1025;
    return t[29:20];
  endfunction

  // double, plus one above the knee
  function automatic logic [7:0] dbl_top(input logic [6:0] v);
    logic [7:0] d;
    d = {v, 1'b0};
    return (d > DBL_KNEE) ? d + 8'd1 : d;
  endfunction

endpackage

// File: rtl/mcpwm_in_if.sv
// input channel: tick or control change transaction
interface mcpwm_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [4:0] midi_channel;
  logic [6:0] controller;
  logic [6:0] cc_value;

  modport source (output valid, kind, midi_channel, controller, cc_value, input ready);
  modport sink   (input valid, kind, midi_channel, controller, cc_value, output ready);
endinterface

// File: rtl/mcpwm_out_if.sv
// output channel: pwm duty levels and multiplexed segment code
interface mcpwm_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] mux_level;
  logic [9:0] audio_level;
  logic [9:0] aux_one_level;
  logic [9:0] aux_two_level;
  logic [9:0] aux_three_level;
  logic [7:0] led_level;

  modport source (output valid, mux_level, audio_level, aux_one_level, aux_two_level,
                  aux_three_level, led_level, input ready);
  modport sink   (input valid, mux_level, audio_level, aux_one_level, aux_two_level,
                  aux_three_level, led_level, output ready);
endinterface

// File: rtl/midi_cc_to_pwm_channel_mux.sv
// top level: midi control change to pwm levels with multiplexed segment output
// the controller steps each accepted transaction through update, segment multiply,
//   scale, output map and result load into the output register, and accepts no new
//   transaction until it is back in idle
// a held result stalls the controller only in its final step
// reset: asynchronous, clears stored levels, tick count, selector, loads config defaults
module midi_cc_to_pwm_channel_mux #(
  parameter int unsigned SEGMENTS = mcpwm_pkg::SEGMENTS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  mcpwm_in_if.sink                         in_i,
  mcpwm_out_if.source                      out_o,
  input  logic                             cfg_we_i,
  input  logic [mcpwm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mcpwm_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  mcpwm_pkg::cmd_t  cmd;
  mcpwm_pkg::stat_t stat;

  mcpwm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  mcpwm_dp #(
    .SEGMENTS (SEGMENTS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .kind_i            (in_i.kind),
    .midi_channel_i    (in_i.midi_channel),
    .controller_i      (in_i.controller),
    .cc_value_i        (in_i.cc_value),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_valid_o       (out_o.valid),
    .out_ready_i       (out_o.ready),
    .mux_level_o       (out_o.mux_level),
    .audio_level_o     (out_o.audio_level),
    .aux_one_level_o   (out_o.aux_one_level),
    .aux_two_level_o   (out_o.aux_two_level),
    .aux_three_level_o (out_o.aux_three_level),
    .led_level_o       (out_o.led_level)
  );

endmodule

// File: rtl/mcpwm_dp.sv
// datapath: level state, config registers, segment code arithmetic, output register
module mcpwm_dp #(
  parameter int unsigned SEGMENTS = mcpwm_pkg::SEGMENTS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             kind_i,
  input  logic [4:0]                       midi_channel_i,
  input  logic [6:0]                       controller_i,
  input  logic [6:0]                       cc_value_i,
  input  logic                             cfg_we_i,
  input  logic [mcpwm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mcpwm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  mcpwm_pkg::cmd_t                  cmd_i,
  output mcpwm_pkg::stat_t                 stat_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [9:0]                       mux_level_o,
  output logic [9:0]                       audio_level_o,
  output logic [9:0]                       aux_one_level_o,
  output logic [9:0]                       aux_two_level_o,
  output logic [9:0]                       aux_three_level_o,
  output logic [7:0]                       led_level_o
);

  localparam int unsigned SEL_W = $clog2(SEGMENTS);

  // configuration
  logic [15:0] interval_q;
  logic [6:0]  seg_max_q;
  logic [2:0]  forced_q;

  // architectural state
  logic [16:0]      elapsed_q;
  logic [SEL_W-1:0] sel_q;
  logic [6:0]       seg_q [SEGMENTS];
  logic [7:0]       audio_q;
  logic [7:0]       aux_q [mcpwm_pkg::AUX_COUNT];
  logic [7:0]       led_q;

  // work registers
  logic             aud_pend_q;
  logic [13:0]      aprod_q;
  logic [SEL_W-1:0] k_q;
  logic [13:0]      sprod_q;
  logic [9:0]       x_q;
  logic [19:0]      n_q;

  // output register
  logic       out_valid_q;
  logic [9:0] mux_lvl_q;
  logic [9:0] audio_lvl_q;
  logic [9:0] aux1_lvl_q;
  logic [9:0] aux2_lvl_q;
  logic [9:0] aux3_lvl_q;
  logic [7:0] led_lvl_q;

  logic [16:0]      elapsed_inc;
  logic             cc_ch1;
  logic             is_aux_cc;
  logic             is_seg_cc;
  logic [6:0]       aux_off;
  logic [6:0]       seg_off;
  logic [SEL_W-1:0] k_sel;
  logic [7:0]       audio_a;
  logic [9:0]       x_d;

  assign elapsed_inc = elapsed_q + 17'd1;
  assign cc_ch1      = (kind_i == mcpwm_pkg::KIND_CC) &&
                       (midi_channel_i == mcpwm_pkg::MIDI_CH_ACTIVE);
  assign aux_off     = controller_i - mcpwm_pkg::CC_AUX_FIRST;
  assign seg_off     = controller_i - mcpwm_pkg::CC_SEG_FIRST;
  assign is_aux_cc   = (controller_i >= mcpwm_pkg::CC_AUX_FIRST) &&
                       (controller_i <= mcpwm_pkg::CC_AUX_LAST);
  assign is_seg_cc   = (controller_i >= mcpwm_pkg::CC_SEG_FIRST) &&
                       (32'(seg_off) < SEGMENTS);
  assign k_sel       = (32'(forced_q) < SEGMENTS) ? forced_q[SEL_W-1:0] : sel_q;
  assign audio_a     = mcpwm_pkg::AUDIO_FLOOR + mcpwm_pkg::div127(aprod_q);
  assign x_d         = mcpwm_pkg::SEG_BASE + (10'(k_q) << mcpwm_pkg::SEG_STEP_LOG2) +
                       10'(mcpwm_pkg::div127(sprod_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= mcpwm_pkg::INTERVAL_RST;
      seg_max_q  <= mcpwm_pkg::SEG_MAX_RST;
      forced_q   <= mcpwm_pkg::FORCED_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mcpwm_pkg::CFG_INTERVAL: interval_q <= cfg_data_i;
        mcpwm_pkg::CFG_SEG_MAX:  seg_max_q  <= cfg_data_i[6:0];
        mcpwm_pkg::CFG_FORCED:   forced_q   <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q  <= '0;
      sel_q      <= '0;
      audio_q    <= '0;
      led_q      <= '0;
      aud_pend_q <= 1'b0;
      for (int i = 0; i < SEGMENTS; i++) begin
        seg_q[i] <= '0;
      end
      for (int i = 0; i < mcpwm_pkg::AUX_COUNT; i++) begin
        aux_q[i] <= '0;
      end
    end else begin
      if (cmd_i.apply) begin
        aud_pend_q <= cc_ch1 && (controller_i == mcpwm_pkg::CC_AUDIO);
        if (kind_i == mcpwm_pkg::KIND_TICK) begin
          if (elapsed_inc > {1'b0, interval_q}) begin
            sel_q     <= sel_q + SEL_W'(1);
            elapsed_q <= '0;
          end else begin
            elapsed_q <= elapsed_inc;
          end
        end else if (cc_ch1) begin
          if (controller_i == mcpwm_pkg::CC_AUDIO) begin
            led_q <= {cc_value_i, 1'b0};
          end else if (is_aux_cc) begin
            aux_q[aux_off[mcpwm_pkg::AUX_IDX_W-1:0]] <= mcpwm_pkg::dbl_top(cc_value_i);
          end else if (is_seg_cc) begin
            seg_q[seg_off[SEL_W-1:0]] <= cc_value_i;
          end
        end
      end
      // the audio floor-offset map finishes in the multiply step
      if (cmd_i.mul && aud_pend_q) begin
        audio_q <= mcpwm_pkg::dbl_top(audio_a[6:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      aprod_q <= 14'(cc_value_i) * 14'(mcpwm_pkg::AUDIO_SLOPE);
    end
    if (cmd_i.mul) begin
      k_q     <= k_sel;
      sprod_q <= 14'(seg_q[k_sel]) * 14'(seg_max_q);
    end
    if (cmd_i.scale) begin
      x_q <= x_d;
    end
    if (cmd_i.map) begin
      n_q <= 20'(x_q) * 20'(mcpwm_pkg::OUT_SPAN);
    end
    if (cmd_i.load) begin
      mux_lvl_q   <= mcpwm_pkg::OUT_FLOOR + mcpwm_pkg::div1023(n_q);
      audio_lvl_q <= {audio_q, 2'b00};
      aux1_lvl_q  <= {aux_q[0], 2'b00};
      aux2_lvl_q  <= {aux_q[1], 2'b00};
      aux3_lvl_q  <= {aux_q[2], 2'b00};
      led_lvl_q   <= led_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.out_busy   = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign mux_level_o       = mux_lvl_q;
  assign audio_level_o     = audio_lvl_q;
  assign aux_one_level_o   = aux1_lvl_q;
  assign aux_two_level_o   = aux2_lvl_q;
  assign aux_three_level_o = aux3_lvl_q;
  assign led_level_o       = led_lvl_q;

endmodule

// File: rtl/mcpwm_ctrl.sv
// controller: sequences one transaction through the datapath steps
module mcpwm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output mcpwm_pkg::cmd_t  cmd_o,
  input  mcpwm_pkg::stat_t stat_i
);

  mcpwm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcpwm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mcpwm_pkg::ST_IDLE:  if (in_valid_i) state_d = mcpwm_pkg::ST_MUL;
      mcpwm_pkg::ST_MUL:   state_d = mcpwm_pkg::ST_SCALE;
      mcpwm_pkg::ST_SCALE: state_d = mcpwm_pkg::ST_MAP;
      mcpwm_pkg::ST_MAP:   state_d = mcpwm_pkg::ST_FIN;
      mcpwm_pkg::ST_FIN:   if (!stat_i.out_busy) state_d = mcpwm_pkg::ST_IDLE;
      default:             state_d = mcpwm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      mcpwm_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.apply = in_valid_i;
      end
      mcpwm_pkg::ST_MUL:   cmd_o.mul   = 1'b1;
      mcpwm_pkg::ST_SCALE: cmd_o.scale = 1'b1;
      mcpwm_pkg::ST_MAP:   cmd_o.map   = 1'b1;
      // hold the result until the output register frees up
      mcpwm_pkg::ST_FIN:   cmd_o.load  = !stat_i.out_busy;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.apply, cmd_o.mul, cmd_o.scale, cmd_o.map, cmd_o.load}))
    else $error("more than one datapath command at once");

  a_apply_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.apply |=> state_q == mcpwm_pkg::ST_MUL)
    else $error("accepted transaction did not start the multiply step");

  a_load_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == mcpwm_pkg::ST_IDLE && in_ready_o)
    else $error("controller not back to idle after result load");

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mcpwm_pkg::ST_FIN && stat_i.out_busy) |=> state_q == mcpwm_pkg::ST_FIN)
    else $error("result step left while output register still busy");
`endif

endmodule

// File: bench/testbench.sv
// testbench for the midi control change to pwm level block with segment multiplexing
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned N_PHASES       = 8;
  localparam int unsigned ITEMS_PER_PHASE = 60;
  localparam int unsigned DRAIN_CYCLES    = 10;
  localparam logic [mcpwm_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam logic [6:0] CC_SEG_LAST = mcpwm_pkg::CC_SEG_FIRST + 7'd3;

  typedef struct packed {
    logic       kind;
    logic [4:0] midi_channel;
    logic [6:0] controller;
    logic [6:0] cc_value;
  } midi_item_t;

  typedef struct packed {
    logic [9:0] mux_level;
    logic [9:0] audio_level;
    logic [9:0] aux_one_level;
    logic [9:0] aux_two_level;
    logic [9:0] aux_three_level;
    logic [7:0] led_level;
  } level_set_t;

  // predicts the pwm levels after each transaction and checks them in order
  class level_scoreboard;
    logic [15:0] interval;
    logic [6:0]  seg_max;
    logic [2:0]  forced;
    logic [16:0] elapsed;
    logic [1:0]  sel;
    logic [6:0]  seg_val [mcpwm_pkg::SEGMENTS];
    logic [7:0]  audio;
    logic [7:0]  aux [mcpwm_pkg::AUX_COUNT];
    logic [7:0]  led;
    level_set_t  levels_q [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned ticks;
    int unsigned ccs;

    function new();
      interval = mcpwm_pkg::INTERVAL_RST;
      seg_max  = mcpwm_pkg::SEG_MAX_RST;
      forced   = mcpwm_pkg::FORCED_RST;
      elapsed  = '0;
      sel      = '0;
      foreach (seg_val[i]) seg_val[i] = '0;
      foreach (aux[i]) aux[i] = '0;
      audio    = '0;
      led      = '0;
      errors   = 0;
      checked  = 0;
      ticks    = 0;
      ccs      = 0;
    endfunction

    function void write_reg(logic [mcpwm_pkg::CFG_IDX_W-1:0] idx,
                            logic [mcpwm_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        mcpwm_pkg::CFG_INTERVAL: interval = data[15:0];
        mcpwm_pkg::CFG_SEG_MAX:  seg_max  = data[6:0];
        mcpwm_pkg::CFG_FORCED:   forced   = data[2:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] doubled_knee(logic [6:0] v);
      logic [7:0] d;
      d = {v, 1'b0};
      return (d > 8'd128) ? d + 8'd1 : d;
    endfunction

    function logic [9:0] segment_code(logic [1:0] k);
      int unsigned x;
      int unsigned y;
      x = 512 + 128 * k + (int'(seg_val[k]) * int'(seg_max)) / 127;
      y = 130 + (x * 806) / 1023;
      if (y > 1023) y = 1023;
      return y[9:0];
    endfunction

    function void note_input(midi_item_t it);
      int unsigned a;
      level_set_t lv;
      if (it.kind == mcpwm_pkg::KIND_TICK) begin
        ticks++;
        elapsed = elapsed + 17'd1;
        if (elapsed > {1'b0, interval}) begin
          sel     = sel + 2'd1;
          elapsed = '0;
        end
      end else begin
        ccs++;
        if (it.midi_channel == mcpwm_pkg::MIDI_CH_ACTIVE) begin
          if (it.controller == mcpwm_pkg::CC_AUDIO) begin
            a = 10 + (int'(it.cc_value) * 107) / 127;
            if (a > 127) a = 127;
            led   = {it.cc_value, 1'b0};
            audio = doubled_knee(a[6:0]);
          end else if (it.controller >= mcpwm_pkg::CC_AUX_FIRST &&
                       it.controller <= mcpwm_pkg::CC_AUX_LAST) begin
            aux[it.controller - mcpwm_pkg::CC_AUX_FIRST] = doubled_knee(it.cc_value);
          end else if (it.controller >= mcpwm_pkg::CC_SEG_FIRST &&
                       it.controller <= CC_SEG_LAST) begin
            seg_val[it.controller - mcpwm_pkg::CC_SEG_FIRST] = it.cc_value;
          end
        end
      end
      lv.mux_level       = segment_code((forced < 3'd4) ? forced[1:0] : sel);
      lv.audio_level     = {audio, 2'b00};
      lv.aux_one_level   = {aux[0], 2'b00};
      lv.aux_two_level   = {aux[1], 2'b00};
      lv.aux_three_level = {aux[2], 2'b00};
      lv.led_level       = led;
      levels_q.push_back(lv);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(level_set_t got);
      level_set_t want;
      if (levels_q.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result transaction, mux_level %0d", $time,
                 got.mux_level);
        return;
      end
      want = levels_q.pop_front();
      checked++;
      compare_field("mux_level", want.mux_level, got.mux_level);
      compare_field("audio_level", want.audio_level, got.audio_level);
      compare_field("aux_one_level", want.aux_one_level, got.aux_one_level);
      compare_field("aux_two_level", want.aux_two_level, got.aux_two_level);
      compare_field("aux_three_level", want.aux_three_level, got.aux_three_level);
      compare_field("led_level", want.led_level, got.led_level);
    endfunction

    function int unsigned pending();
      return levels_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [mcpwm_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [mcpwm_pkg::CFG_DATA_W-1:0] cfg_data_i;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned reg_settings;
  level_scoreboard levels_sb;

  mcpwm_in_if  in_if ();
  mcpwm_out_if out_if ();

  midi_cc_to_pwm_channel_mux i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #4ms;
    $display("timeout with %0d results outstanding", levels_sb.pending());
    $display("testbench failed");
    $finish;
  end

  // result side: random back-pressure, checked at the rising edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_if.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      levels_sb.check_result({out_if.mux_level, out_if.audio_level, out_if.aux_one_level,
                              out_if.aux_two_level, out_if.aux_three_level,
                              out_if.led_level});
    end
  end

  task automatic cfg_write(input logic [mcpwm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mcpwm_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    levels_sb.write_reg(idx, data);
  endtask

  task automatic apply_settings(input logic [15:0] interval, input logic [6:0] seg_max,
                                input logic [2:0] forced);
    cfg_write(mcpwm_pkg::CFG_INTERVAL, interval);
    cfg_write(mcpwm_pkg::CFG_SEG_MAX, mcpwm_pkg::CFG_DATA_W'(seg_max));
    cfg_write(mcpwm_pkg::CFG_FORCED, mcpwm_pkg::CFG_DATA_W'(forced));
    reg_settings++;
  endtask

  // called at a falling edge, returns at a falling edge with valid low
  task automatic send_item(input midi_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        = 1'b1;
    in_if.kind         = it.kind;
    in_if.midi_channel = it.midi_channel;
    in_if.controller   = it.controller;
    in_if.cc_value     = it.cc_value;
    do @(posedge clk_i); while (!in_if.ready);
    levels_sb.note_input(it);
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  task automatic send_cc(input logic [4:0] chan, input logic [6:0] ctl, input logic [6:0] v);
    send_item({mcpwm_pkg::KIND_CC, chan, ctl, v});
  endtask

  task automatic wait_drained();
    for (int c = 0; c < 20000 && levels_sb.pending() != 0; c++) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic midi_item_t random_item();
    midi_item_t it;
    it.kind = ($urandom_range(99) < 30) ? mcpwm_pkg::KIND_TICK : mcpwm_pkg::KIND_CC;
    it.midi_channel = ($urandom_range(99) < 80) ? mcpwm_pkg::MIDI_CH_ACTIVE :
                                                  5'($urandom_range(31));
    case ($urandom_range(9))
      0, 1:    it.controller = mcpwm_pkg::CC_AUDIO;
      2, 3:    it.controller = mcpwm_pkg::CC_AUX_FIRST + 7'($urandom_range(2));
      4, 5, 6: it.controller = mcpwm_pkg::CC_SEG_FIRST + 7'($urandom_range(3));
      default: it.controller = 7'($urandom_range(127));
    endcase
    if ($urandom_range(9) == 0) begin
      it.cc_value = $urandom_range(1) ? 7'd127 : 7'd0;
    end else begin
      it.cc_value = 7'($urandom_range(127));
    end
    return it;
  endfunction

  initial begin
    logic [15:0] intervals [N_PHASES] = '{16'd0, 16'd65535, 16'd3, 16'd2,
                                          16'd1, 16'd5, 16'd0, 16'd7};
    logic [6:0]  seg_maxes [N_PHASES] = '{7'd0, 7'd127, 7'd55, 7'd100,
                                          7'd127, 7'd64, 7'd127, 7'd1};
    logic [2:0]  forceds [N_PHASES]   = '{3'd0, 3'd4, 3'd1, 3'd7,
                                          3'd2, 3'd3, 3'd5, 3'd6};
    levels_sb          = new();
    reg_settings       = 0;
    send_idle_pct      = 37;
    recv_idle_pct      = 79;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = mcpwm_pkg::CFG_INTERVAL;
    cfg_data_i         = '0;
    in_if.valid        = 1'b0;
    in_if.kind         = mcpwm_pkg::KIND_TICK;
    in_if.midi_channel = '0;
    in_if.controller   = '0;
    in_if.cc_value     = '0;
    out_if.ready       = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: reset levels first, then the map corners
    send_item({mcpwm_pkg::KIND_TICK, 5'd0, 7'd0, 7'd0});
    wait_drained();
    apply_settings(16'd1, 7'd127, 3'd4);
    send_cc(mcpwm_pkg::MIDI_CH_ACTIVE, mcpwm_pkg::CC_AUDIO, 7'd0);
    send_cc(mcpwm_pkg::MIDI_CH_ACTIVE, mcpwm_pkg::CC_AUDIO, 7'd127);
    send_cc(mcpwm_pkg::MIDI_CH_ACTIVE, mcpwm_pkg::CC_AUDIO, 7'd65);  // audio lands on the knee
    send_cc(mcpwm_pkg::MIDI_CH_ACTIVE, mcpwm_pkg::CC_AUDIO, 7'd66);  // just above the knee
    send_cc(mcpwm_pkg::MIDI_CH_ACTIVE, mcpwm_pkg::CC_AUX_FIRST, 7'd64);
    send_cc(mcpwm_pkg::MIDI_CH_ACTIVE, mcpwm_pkg::CC_AUX_FIRST + 7'd1, 7'd65);
    send_cc(mcpwm_pkg::MIDI_CH_ACTIVE, mcpwm_pkg::CC_AUX_LAST, 7'd127);
    send_cc(mcpwm_pkg::MIDI_CH_ACTIVE, mcpwm_pkg::CC_SEG_FIRST, 7'd127);
    send_cc(mcpwm_pkg::MIDI_CH_ACTIVE, mcpwm_pkg::CC_SEG_FIRST + 7'd1, 7'd0);
    send_cc(mcpwm_pkg::MIDI_CH_ACTIVE, mcpwm_pkg::CC_SEG_FIRST + 7'd2, 7'd85);
    send_cc(mcpwm_pkg::MIDI_CH_ACTIVE, CC_SEG_LAST, 7'd127);
    // ignored: unmapped controllers and other channels; then ticks that step the selector
    send_cc(mcpwm_pkg::MIDI_CH_ACTIVE, mcpwm_pkg::CC_AUDIO + 7'd1, 7'd127);
    send_cc(mcpwm_pkg::MIDI_CH_ACTIVE, mcpwm_pkg::CC_SEG_FIRST - 7'd20, 7'd127);
    send_cc(mcpwm_pkg::MIDI_CH_ACTIVE, 7'd127, 7'd127);
    send_cc(5'd0, mcpwm_pkg::CC_AUDIO, 7'd127);
    send_cc(5'd16, mcpwm_pkg::CC_AUX_FIRST, 7'd127);
    send_cc(5'd31, mcpwm_pkg::CC_SEG_FIRST, 7'd0);
    repeat (8) send_item({mcpwm_pkg::KIND_TICK, 5'd31, 7'd127, 7'd127});

    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      if (p == 0) cfg_write(CFG_IDX_SPARE, mcpwm_pkg::CFG_DATA_W'($urandom));
      apply_settings(intervals[p], seg_maxes[p], forceds[p]);
      case (p * 3 / N_PHASES)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 79;
        end
        1: begin
          send_idle_pct = 79;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (ITEMS_PER_PHASE) send_item(random_item());
    end

    wait_drained();
    $display("ran %0d ticks and %0d control changes across %0d register settings",
             levels_sb.ticks, levels_sb.ccs, reg_settings);
    $display("%0d level sets checked, %0d mismatches, %0d results missing",
             levels_sb.checked, levels_sb.errors, levels_sb.pending());
    if (levels_sb.errors == 0 && levels_sb.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
